@@ rtl/rrqs_pkg.sv @@
// Shared types and codes for the round-robin quantum scheduler.
// No dependencies; imported by every module of the block.
package rrqs_pkg;

	// Input item: one tick or one task arrival
	typedef struct packed {
		logic        opcode;
		logic [7:0]  task_id;
		logic [15:0] burst_time;
	} in_item_t;

	// Result item: one per accepted input item
	typedef struct packed {
		logic [2:0]  event_res;
		logic [7:0]  event_task;
		logic [31:0] finish_time;
		logic [15:0] left_time;
		logic [4:0]  queued;
		logic        dropped;
	} out_item_t;

	// Classified request between front and back
	typedef struct packed {
		logic        arrival;
		logic [7:0]  task_id;
		logic [15:0] burst;
	} req_t;

	// Configuration register values
	typedef struct packed {
		logic [15:0] quantum;
		logic [15:0] completion_limit;
	} cfg_t;

	// Input opcodes
	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_ARRIVAL = 1'b1;

	// Event codes
	localparam logic [2:0] EV_IDLE       = 3'd0;
	localparam logic [2:0] EV_DISPATCHED = 3'd1;
	localparam logic [2:0] EV_RAN        = 3'd2;
	localparam logic [2:0] EV_PREEMPTED  = 3'd3;
	localparam logic [2:0] EV_COMPLETED  = 3'd4;
	localparam logic [2:0] EV_STOPPED    = 3'd5;
	localparam logic [2:0] EV_ARRIVAL    = 3'd6;

	// Configuration register indexes
	localparam logic [7:0] CFG_QUANTUM = 8'd0;
	localparam logic [7:0] CFG_LIMIT   = 8'd1;

	// Reset values of the configuration registers
	localparam logic [15:0] QUANTUM_RST = 16'd4;
	localparam logic [15:0] LIMIT_RST   = 16'd0;

endpackage

@@ rtl/rrqs_front.sv @@
// Front end: classifies input items and holds them in a two-entry request queue.
// Depends on rrqs_pkg.
module rrqs_front #(
	parameter int ID_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rrqs_pkg::in_item_t in_item,
	output logic               req_valid,
	input  logic               req_pop,
	output rrqs_pkg::req_t     req
);
	import rrqs_pkg::*;

	localparam int IDW = (ID_BITS < 8) ? ID_BITS : 8;
	localparam logic [7:0] ID_MASK = 8'((16'd1 << IDW) - 16'd1);

	req_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	req_t       cls;
	logic       push;

	// Classify: decode opcode, keep only the id bits the block stores
	always_comb begin
		cls.arrival = (in_item.opcode == OP_ARRIVAL);
		cls.task_id = in_item.task_id & ID_MASK;
		cls.burst   = in_item.burst_time;
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign req_valid = (cnt_q != 2'd0);
	assign req       = ent_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (req_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, req_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/rrqs_core.sv @@
// Back end: ready queue memory, running slot and tick/arrival execution,
// with the result output register. Depends on rrqs_pkg.
module rrqs_core #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rrqs_pkg::cfg_t      cfg,
	input  logic                req_valid,
	output logic                req_pop,
	input  rrqs_pkg::req_t      req,
	output logic                out_valid,
	input  logic                out_ready,
	output rrqs_pkg::out_item_t out_item
);
	import rrqs_pkg::*;

	localparam int IDW = (ID_BITS < 8) ? ID_BITS : 8;
	localparam int PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int EW  = IDW + 16;
	localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

	typedef enum logic {S_LOAD, S_EXEC} state_t;

	// Ready queue memory, registered read at the head
	logic [EW-1:0] mem [QUEUE_DEPTH];
	logic [EW-1:0] rd_q;
	logic          mem_we;
	logic [EW-1:0] mem_wdata;

	state_t         state_q;
	req_t           req_q;
	logic [PW-1:0]  head_q, tail_q, head_n, tail_n;
	logic [CW-1:0]  count_q, count_n;
	logic           slot_valid_q, slot_valid_n;
	logic [IDW-1:0] slot_task_q, slot_task_n;
	logic [15:0]    slot_left_q, slot_left_n;
	logic [15:0]    slice_q, slice_n;
	logic [31:0]    now_q;
	logic [15:0]    done_q, done_n;
	logic           halted_q, halted_n;
	logic           out_valid_q;
	out_item_t      out_q, res;

	logic           fire;
	logic           full;
	logic [15:0]    left_dec;
	logic [15:0]    slice_inc;

	assign full      = (count_q == CNT_FULL);
	assign fire      = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign req_pop   = (state_q == S_LOAD) && req_valid;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign left_dec  = (slot_left_q != 16'd0) ? slot_left_q - 16'd1 : slot_left_q;
	assign slice_inc = (slice_q != 16'hFFFF) ? slice_q + 16'd1 : slice_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[tail_q] <= mem_wdata;
		end
		rd_q <= mem[head_q];
	end

	// Execute one request: next state of the scheduler and its result
	always_comb begin
		head_n       = head_q;
		tail_n       = tail_q;
		count_n      = count_q;
		slot_valid_n = slot_valid_q;
		slot_task_n  = slot_task_q;
		slot_left_n  = slot_left_q;
		slice_n      = slice_q;
		done_n       = done_q;
		halted_n     = halted_q;
		mem_we       = 1'b0;
		mem_wdata    = {req_q.task_id[IDW-1:0], req_q.burst};
		res          = '0;

		if (req_q.arrival) begin
			// Arrival: push at the tail unless full
			res.event_res  = EV_ARRIVAL;
			res.event_task = req_q.task_id;
			res.left_time  = req_q.burst;
			res.dropped    = full;
			if (!full) begin
				mem_we  = 1'b1;
				tail_n  = (tail_q == PTR_LAST) ? '0 : tail_q + PW'(1);
				count_n = count_q + CW'(1);
			end
		end else if (halted_q) begin
			res.event_res = EV_STOPPED;
		end else if (slot_valid_q) begin
			// Run the slot for one tick
			slot_left_n    = left_dec;
			slice_n        = slice_inc;
			res.event_task = 8'(slot_task_q);
			res.left_time  = left_dec;
			res.event_res  = EV_RAN;
			if (left_dec == 16'd0) begin
				slot_valid_n    = 1'b0;
				done_n          = (done_q != 16'hFFFF) ? done_q + 16'd1 : done_q;
				halted_n        = (cfg.completion_limit != 16'd0) &&
				                  (done_n >= cfg.completion_limit);
				res.event_res   = EV_COMPLETED;
				res.finish_time = now_q;
			end else if (slice_inc >= cfg.quantum) begin
				if (!full) begin
					mem_we        = 1'b1;
					mem_wdata     = {slot_task_q, left_dec};
					tail_n        = (tail_q == PTR_LAST) ? '0 : tail_q + PW'(1);
					count_n       = count_q + CW'(1);
					slot_valid_n  = 1'b0;
					res.event_res = EV_PREEMPTED;
				end else begin
					// No room at the tail: keep running, restart the slice
					slice_n = 16'd0;
				end
			end
		end else if (count_q != '0) begin
			// Dispatch the queue head
			slot_valid_n   = 1'b1;
			slot_task_n    = rd_q[EW-1:16];
			slot_left_n    = rd_q[15:0];
			slice_n        = 16'd0;
			head_n         = (head_q == PTR_LAST) ? '0 : head_q + PW'(1);
			count_n        = count_q - CW'(1);
			res.event_res  = EV_DISPATCHED;
			res.event_task = 8'(rd_q[EW-1:16]);
			res.left_time  = rd_q[15:0];
		end else begin
			res.event_res = EV_IDLE;
		end

		res.queued = 5'(count_n);
		if (!fire) begin
			mem_we = 1'b0;
		end
	end

	// Sequencer, scheduler registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			req_q        <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			slot_valid_q <= 1'b0;
			slot_task_q  <= '0;
			slot_left_q  <= '0;
			slice_q      <= '0;
			now_q        <= '0;
			done_q       <= '0;
			halted_q     <= 1'b0;
			out_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_ready && !fire) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (req_valid) begin
						req_q   <= req;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (fire) begin
						head_q       <= head_n;
						tail_q       <= tail_n;
						count_q      <= count_n;
						slot_valid_q <= slot_valid_n;
						slot_task_q  <= slot_task_n;
						slot_left_q  <= slot_left_n;
						slice_q      <= slice_n;
						done_q       <= done_n;
						halted_q     <= halted_n;
						if (!req_q.arrival) begin
							now_q <= now_q + 32'd1;
						end
						out_q       <= res;
						out_valid_q <= 1'b1;
						state_q     <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule

@@ rtl/round_robin_quantum_scheduler.sv @@
// Top level of the round-robin quantum scheduler: configuration registers,
// front end and back end. Depends on rrqs_pkg, rrqs_front and rrqs_core.
//
// Usage:
//   in_*  : one request per item, a tick (opcode 0) or a task arrival
//           (opcode 1). Every request yields exactly one result on out_*.
//   out_* : results in request order, held in an output register until
//           taken with out_ready.
//   cfg_* : register writes (0 quantum, 1 completion limit), always ready;
//           other indexes are ignored. Write only while the block is idle.
// A request goes from the request queue to the back end's request register,
//   and its result to the output register. The back end takes one request at a
//   time: load (read the ready-queue head), then execute, before the next load.
// The two-entry request queue keeps taking requests while the back end or
//   the receiver stalls; when out_ready stays low, the back end holds the
//   next request and in_ready drops once the request queue is full.
// Reset: queue empty, no task running, time zero, registers at quantum 4
//   and no limit. The ready-queue memory needs no clearing pass.
module round_robin_quantum_scheduler #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rrqs_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output rrqs_pkg::out_item_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import rrqs_pkg::*;

	cfg_t cfg_q;
	logic req_valid;
	logic req_pop;
	req_t req;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quantum          <= QUANTUM_RST;
			cfg_q.completion_limit <= LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_QUANTUM: cfg_q.quantum          <= cfg_data;
				CFG_LIMIT:   cfg_q.completion_limit <= cfg_data;
				default:     cfg_q                  <= cfg_q;
			endcase
		end
	end

	rrqs_front #(
		.ID_BITS(ID_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.req_valid(req_valid),
		.req_pop  (req_pop),
		.req      (req)
	);

	rrqs_core #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.ID_BITS    (ID_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.req_valid(req_valid),
		.req_pop  (req_pop),
		.req      (req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

endmodule

@@ tb/sv/sched_tb_pkg.sv @@
`timescale 1ns / 100ps
// Scoreboard for the round-robin quantum scheduler testbench. It tracks the ready
// queue, the running slot and the registers, predicts each result and checks it.
// Depends on rrqs_pkg.
package sched_tb_pkg;
	import rrqs_pkg::*;

	localparam int QDEPTH = 16;

	class sched_scoreboard;
		// Register copies
		bit [15:0] quantum      = QUANTUM_RST;
		bit [15:0] finish_limit = LIMIT_RST;

		// Ready queue: circular store of id and remaining burst
		bit [7:0]    rq_id   [QDEPTH];
		bit [15:0]   rq_left [QDEPTH];
		int unsigned rq_head  = 0;
		int unsigned rq_tail  = 0;
		int unsigned rq_count = 0;

		// Running slot and global counters
		bit        run_valid = 1'b0;
		bit [7:0]  run_task  = '0;
		bit [15:0] run_left  = '0;
		bit [15:0] run_slice = '0;
		bit [31:0] clock_now = '0;
		bit [15:0] retired   = '0;
		bit        stopped   = 1'b0;

		out_item_t   expected_events[$];
		int          errors   = 0;
		int unsigned requests = 0;
		int unsigned results  = 0;
		int unsigned drops    = 0;
		int unsigned seen[8];

		function void write_reg(logic [7:0] reg_index, logic [15:0] value);
			case (reg_index)
				CFG_QUANTUM: quantum = value;
				CFG_LIMIT:   finish_limit = value;
				default: ;
			endcase
		endfunction

		function bit rq_push(bit [7:0] id, bit [15:0] left);
			if (rq_count >= QDEPTH)
				return 1'b0;
			rq_id[rq_tail]   = id;
			rq_left[rq_tail] = left;
			rq_tail = (rq_tail + 1) % QDEPTH;
			rq_count++;
			return 1'b1;
		endfunction

		// Advance the schedule by one accepted request and queue its result
		function void schedule_request(in_item_t r);
			out_item_t e;
			bit ok;
			e = '0;
			requests++;
			if (r.opcode == OP_ARRIVAL) begin
				ok = rq_push(r.task_id, r.burst_time);
				e.event_res  = EV_ARRIVAL;
				e.event_task = r.task_id;
				e.left_time  = r.burst_time;
				e.dropped    = !ok;
			end else begin
				if (stopped) begin
					e.event_res = EV_STOPPED;
				end else if (run_valid) begin
					if (run_left != 0)
						run_left--;
					if (run_slice != 16'hFFFF)
						run_slice++;
					e.event_task = run_task;
					if (run_left == 0) begin
						// retire; limit is only looked at here
						run_valid = 1'b0;
						if (retired != 16'hFFFF)
							retired++;
						if (finish_limit != 0 && retired >= finish_limit)
							stopped = 1'b1;
						e.event_res   = EV_COMPLETED;
						e.finish_time = clock_now;
					end else if (run_slice >= quantum) begin
						// slice used up; a full queue keeps the task running
						e.left_time = run_left;
						if (rq_push(run_task, run_left)) begin
							run_valid   = 1'b0;
							e.event_res = EV_PREEMPTED;
						end else begin
							run_slice   = '0;
							e.event_res = EV_RAN;
						end
					end else begin
						e.event_res = EV_RAN;
						e.left_time = run_left;
					end
				end else if (rq_count != 0) begin
					run_task  = rq_id[rq_head];
					run_left  = rq_left[rq_head];
					rq_head   = (rq_head + 1) % QDEPTH;
					rq_count--;
					run_valid = 1'b1;
					run_slice = '0;
					e.event_res  = EV_DISPATCHED;
					e.event_task = run_task;
					e.left_time  = run_left;
				end else begin
					e.event_res = EV_IDLE;
				end
				clock_now++;
			end
			e.queued = 5'(rq_count);
			expected_events = {expected_events, e};
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h",
					$time, name, want, got);
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			results++;
			seen[got.event_res]++;
			if (got.dropped === 1'b1)
				drops++;
			if (expected_events.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %0h",
					$time, got);
				return;
			end
			want = expected_events.pop_front();
			compare_field("event_res",   32'(want.event_res),   32'(got.event_res));
			compare_field("event_task",  32'(want.event_task),  32'(got.event_task));
			compare_field("finish_time", want.finish_time,      got.finish_time);
			compare_field("left_time",   32'(want.left_time),   32'(got.left_time));
			compare_field("queued",      32'(want.queued),      32'(got.queued));
			compare_field("dropped",     32'(want.dropped),     32'(got.dropped));
		endfunction

		function int pending();
			return expected_events.size();
		endfunction
	endclass

endpackage

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench top for the round-robin quantum scheduler: drives ticks, arrivals and
// register writes with random gaps and stalls, and checks every result in order.
// Depends on rrqs_pkg, sched_tb_pkg and the scheduler RTL.
module tb_top;
	import rrqs_pkg::*;
	import sched_tb_pkg::*;

	localparam logic [7:0] CFG_UNUSED   = 8'hA5;
	localparam int         WATCHDOG_MAX = 2000;
	localparam int         DRAIN_CYCLES = 6;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	in_item_t    in_item   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_item;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	bit rush_in  = 1'b0;
	bit rush_out = 1'b0;
	int idle_cycles = 0;
	sched_scoreboard sb;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	round_robin_quantum_scheduler #(
		.QUEUE_DEPTH(QDEPTH),
		.ID_BITS(8)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	function automatic in_item_t make_item(logic op, logic [7:0] id, logic [15:0] burst);
		in_item_t r;
		r.opcode     = op;
		r.task_id    = id;
		r.burst_time = burst;
		return r;
	endfunction

	// Mostly short bursts so tasks finish; a few long ones and full-range ones
	function automatic in_item_t random_request(int arrival_pct);
		in_item_t r;
		int pick;
		r.task_id = 8'($urandom_range(0, 255));
		r.opcode  = ($urandom_range(1, 100) <= arrival_pct) ? OP_ARRIVAL : OP_TICK;
		pick = $urandom_range(1, 100);
		if (pick <= 70)
			r.burst_time = 16'($urandom_range(0, 6));
		else if (pick <= 97)
			r.burst_time = 16'($urandom_range(7, 40));
		else
			r.burst_time = 16'($urandom_range(0, 65535));
		return r;
	endfunction

	// Valid stays high across back-to-back requests; it drops only for a gap or when settling
	task automatic send_request(in_item_t r);
		int gap;
		gap = rush_in ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= r;
		do @(posedge clk); while (!in_ready);
		sb.schedule_request(r);
	endtask

	task automatic write_cfg(logic [7:0] idx, logic [15:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.write_reg(idx, value);
	endtask

	task automatic run_random(int count, int arrival_pct);
		int n;
		for (n = 0; n < count; n++) begin
			// occasional stretches with no gaps or stalls
			if (n % 32 == 0) begin
				rush_in  = ($urandom_range(0, 3) == 0);
				rush_out = ($urandom_range(0, 3) == 0);
			end
			send_request(random_request(arrival_pct));
		end
	endtask

	// Let every pending result drain before touching the registers
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Result side: random stall before each result
	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = rush_out ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_result(out_item);
		end
	end

	// Watchdog on cycles where nothing moves on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
			    (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_MAX) begin
				$display("%0t: watchdog, nothing moved for %0d cycles", $time, WATCHDOG_MAX);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int n;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: quantum 1, no limit, a write to an unmapped index is dropped
		write_cfg(CFG_QUANTUM, 16'd1);
		write_cfg(CFG_LIMIT, 16'd0);
		write_cfg(CFG_UNUSED, 16'd2);
		send_request(make_item(OP_TICK, 8'h00, 16'h0000));     // empty queue: idle
		send_request(make_item(OP_ARRIVAL, 8'hFF, 16'hFFFF));
		send_request(make_item(OP_ARRIVAL, 8'h00, 16'h0000));  // zero burst
		send_request(make_item(OP_TICK, 8'hFF, 16'hFFFF));     // dispatch
		send_request(make_item(OP_TICK, 8'h00, 16'h0000));     // preempt after one tick
		send_request(make_item(OP_TICK, 8'h3C, 16'h5A5A));     // dispatch zero burst
		send_request(make_item(OP_TICK, 8'hC3, 16'hA5A5));     // completes at once
		for (n = 0; n < 15; n++)
			send_request(make_item(OP_ARRIVAL, 8'($urandom_range(1, 254)),
				16'($urandom_range(1, 5))));
		send_request(make_item(OP_ARRIVAL, 8'h5A, 16'd3));     // queue full: dropped
		send_request(make_item(OP_TICK, 8'($urandom), 16'($urandom)));
		send_request(make_item(OP_ARRIVAL, 8'hA5, 16'd2));     // refill the freed entry
		send_request(make_item(OP_TICK, 8'($urandom), 16'($urandom))); // no room to preempt
		settle();

		// Reset quantum, highest limit
		write_cfg(CFG_QUANTUM, QUANTUM_RST);
		write_cfg(CFG_LIMIT, 16'hFFFF);
		run_random(150, 20);
		settle();

		// Zero quantum behaves as one
		write_cfg(CFG_QUANTUM, 16'd0);
		run_random(80, 25);
		settle();

		// Largest quantum: tasks mostly run to completion
		write_cfg(CFG_QUANTUM, 16'hFFFF);
		write_cfg(CFG_UNUSED, 16'($urandom));
		run_random(50, 20);
		settle();

		// Heavy arrivals: full queue, drops and preemption into a full queue
		write_cfg(CFG_QUANTUM, 16'($urandom_range(2, 7)));
		run_random(150, 50);
		settle();

		write_cfg(CFG_QUANTUM, 16'd1);
		run_random(60, 15);
		settle();

		// Limit lowered below the completed count: the next completion stops
		// scheduling, arrivals are still taken afterwards
		write_cfg(CFG_QUANTUM, 16'd3);
		write_cfg(CFG_LIMIT, 16'd1);
		run_random(80, 25);
		settle();

		$display("%0d requests, %0d results; quantum 0,1,3,4,2..7,65535; limit 0,65535,1",
			sb.requests, sb.results);
		$display("idle %0d disp %0d ran %0d preempt %0d done %0d stop %0d arr %0d (%0d drop)",
			sb.seen[EV_IDLE], sb.seen[EV_DISPATCHED], sb.seen[EV_RAN],
			sb.seen[EV_PREEMPTED], sb.seen[EV_COMPLETED], sb.seen[EV_STOPPED],
			sb.seen[EV_ARRIVAL], sb.drops);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
